@@ rtl/gmcsr_pkg.sv @@
// shared types and constants for the maze grid to csr graph block
// no dependencies; used by every module of the block
package gmcsr_pkg;

   // fixed field widths
   localparam int unsigned VERTEX_W    = 20;
   localparam int unsigned EDGE_W      = 22;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned QUEUE_DEPTH = 4;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   // input item modes
   localparam logic MODE_CELL  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // classified cell kinds as kept in the line buffer
   typedef enum logic [1:0] {
      KIND_BLOCKED = 2'd0,
      KIND_PASS    = 2'd1,
      KIND_START   = 2'd2,
      KIND_DEST    = 2'd3
   } kind_type;

   // work codes passed from the front to the back
   typedef enum logic [1:0] {
      OP_CELL  = 2'd0,
      OP_DRAIN = 2'd1,
      OP_FINAL = 2'd2
   } op_type;

   // one queued unit of work
   typedef struct packed {
      op_type               code;
      kind_type             kind;
      logic [VERTEX_W-1:0]  vertex;
      logic                 form;
      logic                 has_up;
      logic                 has_down;
   } work_type;

   // input item
   typedef struct packed {
      logic       mode;
      logic [7:0] cell_char;
   } req_type;

   // result item
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex_number;
      logic [EDGE_W-1:0]   edge_start;
      logic [3:0]          neighbor_mask;
      logic [VERTEX_W-1:0] up_vertex;
      logic [VERTEX_W-1:0] down_vertex;
      logic [VERTEX_W-1:0] left_vertex;
      logic [VERTEX_W-1:0] right_vertex;
      logic [1:0]          cell_role;
      logic                last_record;
   } rsp_type;

endpackage

@@ rtl/gmcsr_front.sv @@
// front end: accepts maze items, classifies cells and tracks raster position
// depends on gmcsr_pkg; feeds gmcsr_queue
module gmcsr_front #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  grid_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] grid_h,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gmcsr_pkg::req_type    req_data,
   input  logic                  q_full,
   output logic                  push,
   output gmcsr_pkg::work_type   push_data
);

   localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CB = $clog2(MAX_WIDTH);
   localparam int unsigned RB = $clog2(MAX_HEIGHT + 1);

   localparam logic [7:0] CHAR_WALL  = 8'h58;
   localparam logic [7:0] CHAR_OPEN  = 8'h2e;
   localparam logic [7:0] CHAR_START = 8'h53;
   localparam logic [7:0] CHAR_DEST  = 8'h45;

   logic [RB-1:0]                      row_ff, row_in;
   logic [CB-1:0]                      col_ff, col_in;
   logic [WB-1:0]                      drain_ff, drain_in;
   logic [gmcsr_pkg::VERTEX_W-1:0]     vcount_ff, vcount_in;
   logic                               accept;
   logic                               complete;
   logic                               last_col;
   gmcsr_pkg::kind_type                kind;

   // unknown characters count as walls
   function automatic gmcsr_pkg::kind_type classify(input logic [7:0] ch);
      gmcsr_pkg::kind_type k;
      case (ch)
         CHAR_WALL:  k = gmcsr_pkg::KIND_BLOCKED;
         CHAR_OPEN:  k = gmcsr_pkg::KIND_PASS;
         CHAR_START: k = gmcsr_pkg::KIND_START;
         CHAR_DEST:  k = gmcsr_pkg::KIND_DEST;
         default:    k = gmcsr_pkg::KIND_BLOCKED;
      endcase
      return k;
   endfunction

   // position tracking and work generation
   always_comb begin
      accept    = req_valid && !q_full;
      req_stall = q_full;
      complete  = row_ff >= grid_h;
      last_col  = (WB'(col_ff) + WB'(1)) == grid_w;
      kind      = classify(req_data.cell_char);

      row_in    = row_ff;
      col_in    = col_ff;
      drain_in  = drain_ff;
      vcount_in = vcount_ff;
      push      = 1'b0;

      push_data.code     = gmcsr_pkg::OP_CELL;
      push_data.kind     = kind;
      push_data.vertex   = vcount_ff;
      push_data.form     = row_ff != '0;
      push_data.has_up   = row_ff > RB'(1);
      push_data.has_down = 1'b1;

      if (accept) begin
         if (req_data.mode == gmcsr_pkg::MODE_CELL) begin
            if (!complete) begin
               push = 1'b1;
               if (kind != gmcsr_pkg::KIND_BLOCKED) begin
                  vcount_in = vcount_ff + gmcsr_pkg::VERTEX_W'(1);
               end
               if (last_col) begin
                  col_in = '0;
                  row_in = row_ff + RB'(1);
               end else begin
                  col_in = col_ff + CB'(1);
               end
            end
         end else if (complete) begin
            push               = 1'b1;
            push_data.kind     = gmcsr_pkg::KIND_BLOCKED;
            push_data.vertex   = '0;
            push_data.has_down = 1'b0;
            if (drain_ff < grid_w) begin
               // last row is formed without a row below
               push_data.code   = gmcsr_pkg::OP_DRAIN;
               push_data.form   = 1'b1;
               push_data.has_up = grid_h > RB'(1);
               drain_in         = drain_ff + WB'(1);
            end else begin
               // flush and start over for the next maze
               push_data.code   = gmcsr_pkg::OP_FINAL;
               push_data.form   = 1'b0;
               push_data.has_up = 1'b0;
               row_in           = '0;
               col_in           = '0;
               drain_in         = '0;
               vcount_in        = '0;
            end
         end
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff    <= '0;
         col_ff    <= '0;
         drain_ff  <= '0;
         vcount_ff <= '0;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         drain_ff  <= drain_in;
         vcount_ff <= vcount_in;
      end
   end

endmodule

@@ rtl/gmcsr_queue.sv @@
// short work queue between the front and the back
// depends on gmcsr_pkg for the work type and depth
module gmcsr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gmcsr_pkg::work_type  push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output gmcsr_pkg::work_type  head
);

   localparam int unsigned DEPTH = gmcsr_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   gmcsr_pkg::work_type q_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   // pointer and fill level update
   always_comb begin
      full      = cnt_ff == CNT_W'(DEPTH);
      not_empty = cnt_ff != '0;
      head      = q_ff[rd_ff];
      wr_in     = push ? PTR_W'(wr_ff + PTR_W'(1)) : wr_ff;
      rd_in     = pop ? PTR_W'(rd_ff + PTR_W'(1)) : rd_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   // the front must hold off while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("work pushed into a full queue");
`endif

endmodule

@@ rtl/gmcsr_back.sv @@
// back end: line buffer, neighbor window, edge offsets, held and output record
// depends on gmcsr_pkg; drains gmcsr_queue
module gmcsr_back #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] grid_w,
   input  logic                  op_valid,
   input  gmcsr_pkg::work_type   op_data,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gmcsr_pkg::rsp_type    rsp_data
);

   localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CB = $clog2(MAX_WIDTH);
   localparam int unsigned VW = gmcsr_pkg::VERTEX_W;
   localparam int unsigned EW = gmcsr_pkg::EDGE_W;

   localparam int unsigned NB_UP    = 0;
   localparam int unsigned NB_DOWN  = 1;
   localparam int unsigned NB_LEFT  = 2;
   localparam int unsigned NB_RIGHT = 3;

   localparam logic [1:0] ROLE_ORDINARY = 2'd0;
   localparam logic [1:0] ROLE_START    = 2'd1;
   localparam logic [1:0] ROLE_DEST     = 2'd2;

   typedef struct packed {
      gmcsr_pkg::kind_type kind;
      logic [VW-1:0]       vertex;
   } entry_type;

   // per column: the previous row and the one before it
   typedef struct packed {
      entry_type p1;
      entry_type p2;
   } word_type;

   word_type            line_ff [MAX_WIDTH];
   word_type            rd_ff;
   word_type            byp_word_ff;
   logic                byp_ff;
   word_type            win_ff, win_in;
   entry_type           left_ff, left_in;
   logic [CB-1:0]       col_ff, col_in;
   logic [EW-1:0]       edge_ff, edge_in;
   gmcsr_pkg::rsp_type  held_ff, held_in;
   logic                held_valid_ff, held_valid_in;
   gmcsr_pkg::rsp_type  out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   word_type            next_word;
   word_type            wword;
   entry_type           center, up_e, down_e, left_e, right_e;
   logic                is_cell, is_final, is_step;
   logic                first_col, last_col;
   logic                formed;
   logic [3:0]          mask;
   logic [2:0]          n_edges;
   logic [WB:0]         sum2;
   logic [CB-1:0]       raddr;
   gmcsr_pkg::rsp_type  rec;

   function automatic logic [1:0] role_of(input gmcsr_pkg::kind_type k);
      logic [1:0] r;
      case (k)
         gmcsr_pkg::KIND_START: r = ROLE_START;
         gmcsr_pkg::KIND_DEST:  r = ROLE_DEST;
         default:               r = ROLE_ORDINARY;
      endcase
      return r;
   endfunction

   // window, record forming and hand-off
   always_comb begin
      pop       = op_valid && (!out_valid_ff || !rsp_stall);
      is_cell   = op_data.code == gmcsr_pkg::OP_CELL;
      is_final  = op_data.code == gmcsr_pkg::OP_FINAL;
      is_step   = !is_final;
      first_col = col_ff == '0;
      last_col  = (WB'(col_ff) + WB'(1)) == grid_w;

      next_word     = byp_ff ? byp_word_ff : rd_ff;
      center        = win_ff.p1;
      up_e          = win_ff.p2;
      left_e        = left_ff;
      right_e       = next_word.p1;
      down_e.kind   = op_data.kind;
      down_e.vertex = op_data.vertex;
      wword.p1      = down_e;
      wword.p2      = center;

      mask[NB_UP]    = op_data.has_up && (up_e.kind != gmcsr_pkg::KIND_BLOCKED);
      mask[NB_DOWN]  = op_data.has_down && (down_e.kind != gmcsr_pkg::KIND_BLOCKED);
      mask[NB_LEFT]  = !first_col && (left_e.kind != gmcsr_pkg::KIND_BLOCKED);
      mask[NB_RIGHT] = !last_col && (right_e.kind != gmcsr_pkg::KIND_BLOCKED);
      n_edges = {2'b00, mask[0]} + {2'b00, mask[1]} + {2'b00, mask[2]} + {2'b00, mask[3]};

      rec.vertex_number = center.vertex;
      rec.edge_start    = edge_ff;
      rec.neighbor_mask = mask;
      rec.up_vertex     = mask[NB_UP] ? up_e.vertex : '0;
      rec.down_vertex   = mask[NB_DOWN] ? down_e.vertex : '0;
      rec.left_vertex   = mask[NB_LEFT] ? left_e.vertex : '0;
      rec.right_vertex  = mask[NB_RIGHT] ? right_e.vertex : '0;
      rec.cell_role     = role_of(center.kind);
      rec.last_record   = 1'b0;

      formed = pop && is_step && op_data.form && (center.kind != gmcsr_pkg::KIND_BLOCKED);

      // prefetch two columns ahead, wrapping at the row end
      sum2 = (WB+1)'(col_ff) + (WB+1)'(2);
      if (grid_w == WB'(1)) begin
         raddr = '0;
      end else if (sum2 >= {1'b0, grid_w}) begin
         raddr = CB'(sum2 - {1'b0, grid_w});
      end else begin
         raddr = CB'(sum2);
      end

      col_in        = col_ff;
      win_in        = win_ff;
      left_in       = left_ff;
      edge_in       = edge_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && rsp_stall;

      // advance the column window
      if (pop && is_step) begin
         col_in  = last_col ? '0 : CB'(col_ff + CB'(1));
         left_in = center;
         win_in  = (is_cell && first_col && last_col) ? wword : next_word;
      end

      // new record goes to the hold slot, the old one moves out
      if (formed) begin
         edge_in = edge_ff + EW'(n_edges);
         if (held_valid_ff) begin
            out_in       = held_ff;
            out_valid_in = 1'b1;
         end
         held_in       = rec;
         held_valid_in = 1'b1;
      end

      // end of maze: release the held record flagged as last
      if (pop && is_final) begin
         if (held_valid_ff) begin
            out_in             = held_ff;
            out_in.last_record = 1'b1;
            out_valid_in       = 1'b1;
         end
         held_valid_in = 1'b0;
         edge_in       = '0;
         col_in        = '0;
      end

      if (restart) begin
         held_valid_in = 1'b0;
         edge_in       = '0;
         col_in        = '0;
      end
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         edge_ff       <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         edge_ff       <= edge_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      win_ff  <= win_in;
      left_ff <= left_in;
      held_ff <= held_in;
      out_ff  <= out_in;
   end

   // line buffer with registered read and write bypass
   always_ff @(posedge clock) begin
      if (pop && is_cell) begin
         line_ff[col_ff] <= wword;
      end
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (pop && is_step) begin
         byp_ff <= is_cell && (raddr == col_ff);
      end
      if (pop && is_step) begin
         rd_ff       <= line_ff[raddr];
         byp_word_ff <= wword;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   // column pointer always inside the configured width
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WB'(col_ff) < grid_w)
      else $error("column pointer beyond grid width");

   // end of maze clears the hold slot and edge offset
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (pop && is_final) |=> (!held_valid_ff && edge_ff == '0))
      else $error("state left over after end of maze");

   // no work taken means no change to offsets or position
   a_idle_stable: assert property (@(posedge clock) disable iff (reset)
      (!pop && !restart) |=> ($stable(edge_ff) && $stable(col_ff)))
      else $error("back state moved without work");
`endif

endmodule

@@ rtl/grid_maze_to_csr_graph_core.sv @@
// top level of the maze grid to csr graph block
// depends on gmcsr_pkg, gmcsr_front, gmcsr_queue and gmcsr_back
//
// usage:
//  - req channel carries one maze cell character (mode 0) or a drain step
//    (mode 1); cells come in row-major order, grid_width x grid_height of
//    them, then grid_width + 1 drain steps close the maze
//  - rsp channel carries one record per open cell: vertex number, first
//    edge offset, open neighbors and role; the final record of a maze has
//    last_record set and comes out on the last drain step
//  - csr port writes grid_width (index 0) or grid_height (index 1), clamped
//    to 1..MAX_WIDTH / 1..MAX_HEIGHT; a write restarts the maze
//  - throughput is one item per cycle unless stalled; the line buffer has
//    one write and one prefetch read per cycle, so no item waits on another
//  - a record released by an accepted item passes the work queue and
//    then the output register before it leaves
//  - while rsp_stall is high a waiting output record holds and the back
//    end stops; the four-entry queue then fills and req_stall rises
//  - reset clears positions and counters and sets both sizes to 1; the
//    line buffer is not cleared, every entry is written before it is used
module grid_maze_to_csr_graph_core #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gmcsr_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gmcsr_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_wen,
   input  logic [gmcsr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gmcsr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RB = $clog2(MAX_HEIGHT + 1);

   logic [WB-1:0]        grid_w_ff, grid_w_in;
   logic [RB-1:0]        grid_h_ff, grid_h_in;
   logic                 q_full;
   logic                 q_not_empty;
   logic                 push;
   logic                 pop;
   gmcsr_pkg::work_type  push_data;
   gmcsr_pkg::work_type  head;

   // size registers, stored already clamped
   always_comb begin
      grid_w_in = grid_w_ff;
      grid_h_in = grid_h_ff;
      if (csr_wen) begin
         case (csr_index)
            gmcsr_pkg::CSR_GRID_WIDTH: begin
               if (csr_wdata == '0) begin
                  grid_w_in = WB'(1);
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  grid_w_in = WB'(MAX_WIDTH);
               end else begin
                  grid_w_in = WB'(csr_wdata);
               end
            end
            gmcsr_pkg::CSR_GRID_HEIGHT: begin
               if (csr_wdata == '0) begin
                  grid_h_in = RB'(1);
               end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                  grid_h_in = RB'(MAX_HEIGHT);
               end else begin
                  grid_h_in = RB'(csr_wdata);
               end
            end
            default: begin
               grid_w_in = grid_w_ff;
               grid_h_in = grid_h_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff <= WB'(1);
         grid_h_ff <= RB'(1);
      end else begin
         grid_w_ff <= grid_w_in;
         grid_h_ff <= grid_h_in;
      end
   end

   gmcsr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_wen),
      .grid_w     (grid_w_ff),
      .grid_h     (grid_h_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_data  (push_data)
   );

   gmcsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head)
   );

   gmcsr_back #(
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_wen),
      .grid_w     (grid_w_ff),
      .op_valid   (q_not_empty),
      .op_data    (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ verif/gmcsr_tb_pkg.sv @@
`timescale 1ns / 100ps
// maze record prediction and checking for the grid maze to csr graph testbench
// depends on gmcsr_pkg for the transfer types and the cell kind codes
package gmcsr_tb_pkg;

   import gmcsr_pkg::*;

   // sizes the block is built with
   localparam int unsigned MAZE_MAX_W = 1024;
   localparam int unsigned MAZE_MAX_H = 1024;
   localparam int unsigned LINE_SLOTS = 3 * MAZE_MAX_W;

   // cell characters
   localparam logic [7:0] CH_WALL  = "X";
   localparam logic [7:0] CH_OPEN  = ".";
   localparam logic [7:0] CH_START = "S";
   localparam logic [7:0] CH_DEST  = "E";

   // record role codes
   localparam logic [1:0] ROLE_ORDINARY = 2'd0;
   localparam logic [1:0] ROLE_START    = 2'd1;
   localparam logic [1:0] ROLE_DEST     = 2'd2;

   // neighbor mask bit positions
   localparam int NB_UP    = 0;
   localparam int NB_DOWN  = 1;
   localparam int NB_LEFT  = 2;
   localparam int NB_RIGHT = 3;

   class maze_record_board;

      // three rows of classified cells and their vertex numbers
      logic [VERTEX_W-1:0] vertex_line [LINE_SLOTS];
      kind_type            kind_line [LINE_SLOTS];
      logic [CSR_DATA_W-1:0] width_reg;
      logic [CSR_DATA_W-1:0] height_reg;
      int unsigned         row_at;
      int unsigned         col_at;
      int unsigned         drain_at;
      logic [20:0]         vertex_count;
      logic [22:0]         edge_count;
      bit                  held_ok;
      rsp_type             held_rec;
      rsp_type             due_records[$];
      int                  errors;

      function new();
         for (int i = 0; i < LINE_SLOTS; i++) begin
            vertex_line[i] = '0;
            kind_line[i] = KIND_BLOCKED;
         end
         width_reg = CSR_DATA_W'(1);
         height_reg = CSR_DATA_W'(1);
         errors = 0;
         restart();
      endfunction

      function void restart();
         row_at = 0;
         col_at = 0;
         drain_at = 0;
         vertex_count = '0;
         edge_count = '0;
         held_ok = 0;
         held_rec = '0;
      endfunction

      // sizes in use, clamped to the built maximum
      function int unsigned cols();
         if (width_reg == 0) return 1;
         if (width_reg > MAZE_MAX_W) return MAZE_MAX_W;
         return 32'(width_reg);
      endfunction

      function int unsigned rows();
         if (height_reg == 0) return 1;
         if (height_reg > MAZE_MAX_H) return MAZE_MAX_H;
         return 32'(height_reg);
      endfunction

      function int unsigned due_count();
         return due_records.size();
      endfunction

      function int unsigned slot_of(int unsigned r, int unsigned c);
         return (r % 3) * MAZE_MAX_W + (c % MAZE_MAX_W);
      endfunction

      // unknown characters count as walls
      function kind_type classify(logic [7:0] ch);
         case (ch)
            CH_OPEN:  return KIND_PASS;
            CH_START: return KIND_START;
            CH_DEST:  return KIND_DEST;
            default:  return KIND_BLOCKED;
         endcase
      endfunction

      // a register write abandons the maze in progress
      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_GRID_WIDTH) width_reg = value;
         else height_reg = value;
         restart();
      endfunction

      // record of cell (r, c); returns 0 for a wall
      function bit build_record(int unsigned r, int unsigned c, bit below,
                                output rsp_type rec);
         int unsigned s;
         int unsigned n;
         kind_type k;
         rec = '0;
         s = slot_of(r, c);
         k = kind_line[s];
         if (k == KIND_BLOCKED) return 0;
         rec.vertex_number = vertex_line[s];
         if (r > 0 && kind_line[slot_of(r + 2, c)] != KIND_BLOCKED) begin
            rec.neighbor_mask[NB_UP] = 1'b1;
            rec.up_vertex = vertex_line[slot_of(r + 2, c)];
         end
         if (below && kind_line[slot_of(r + 1, c)] != KIND_BLOCKED) begin
            rec.neighbor_mask[NB_DOWN] = 1'b1;
            rec.down_vertex = vertex_line[slot_of(r + 1, c)];
         end
         if (c > 0 && kind_line[slot_of(r, c - 1)] != KIND_BLOCKED) begin
            rec.neighbor_mask[NB_LEFT] = 1'b1;
            rec.left_vertex = vertex_line[slot_of(r, c - 1)];
         end
         if (c + 1 < cols() && kind_line[slot_of(r, c + 1)] != KIND_BLOCKED) begin
            rec.neighbor_mask[NB_RIGHT] = 1'b1;
            rec.right_vertex = vertex_line[slot_of(r, c + 1)];
         end
         rec.edge_start = edge_count[EDGE_W-1:0];
         rec.cell_role = (k == KIND_START) ? ROLE_START :
                         (k == KIND_DEST) ? ROLE_DEST : ROLE_ORDINARY;
         n = $countones(rec.neighbor_mask);
         edge_count = edge_count + 23'(n);
         return 1;
      endfunction

      // a new record is held; the one held before is now due
      function void hold_record(rsp_type rec);
         if (held_ok) begin
            held_rec.last_record = 1'b0;
            due_records.push_back(held_rec);
         end
         held_rec = rec;
         held_ok = 1;
      endfunction

      // predicts the records released by one accepted input transfer
      function void predict_from_item(req_type item);
         int unsigned w;
         int unsigned h;
         int unsigned r;
         int unsigned c;
         int unsigned s;
         kind_type k;
         rsp_type rec;
         w = cols();
         h = rows();
         if (item.mode == MODE_CELL) begin
            // cells after a complete grid are dropped
            if (row_at >= h) return;
            r = row_at;
            c = col_at;
            s = slot_of(r, c);
            k = classify(item.cell_char);
            kind_line[s] = k;
            vertex_line[s] = vertex_count[VERTEX_W-1:0];
            if (k != KIND_BLOCKED) vertex_count = vertex_count + 21'(1);
            if (r > 0) begin
               if (build_record(r - 1, c, 1, rec)) hold_record(rec);
            end
            if (c + 1 >= w) begin
               col_at = 0;
               row_at = r + 1;
            end else begin
               col_at = c + 1;
            end
         end else begin
            // drains before the grid is complete are dropped
            if (row_at < h) return;
            if (drain_at < w) begin
               c = drain_at;
               drain_at = drain_at + 1;
               if (build_record(h - 1, c, 0, rec)) hold_record(rec);
            end else begin
               if (held_ok) begin
                  held_rec.last_record = 1'b1;
                  due_records.push_back(held_rec);
               end
               restart();
            end
         end
      endfunction

      function void compare_field(string name, logic [EDGE_W-1:0] want,
                                  logic [EDGE_W-1:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h",
                     $time, name, want, seen);
            errors++;
         end
      endfunction

      // checks one accepted result transfer against the oldest due record
      function void check_record(rsp_type got);
         rsp_type want;
         if (due_records.size() == 0) begin
            $display("%0t: record with none due: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = due_records.pop_front();
         compare_field("vertex_number", EDGE_W'(want.vertex_number),
                       EDGE_W'(got.vertex_number));
         compare_field("edge_start", want.edge_start, got.edge_start);
         compare_field("neighbor_mask", EDGE_W'(want.neighbor_mask),
                       EDGE_W'(got.neighbor_mask));
         compare_field("up_vertex", EDGE_W'(want.up_vertex), EDGE_W'(got.up_vertex));
         compare_field("down_vertex", EDGE_W'(want.down_vertex),
                       EDGE_W'(got.down_vertex));
         compare_field("left_vertex", EDGE_W'(want.left_vertex),
                       EDGE_W'(got.left_vertex));
         compare_field("right_vertex", EDGE_W'(want.right_vertex),
                       EDGE_W'(got.right_vertex));
         compare_field("cell_role", EDGE_W'(want.cell_role), EDGE_W'(got.cell_role));
         compare_field("last_record", EDGE_W'(want.last_record),
                       EDGE_W'(got.last_record));
      endfunction

   endclass

endpackage

@@ verif/grid_maze_to_csr_graph_core_tb.sv @@
`timescale 1ns / 100ps
// testbench top for grid_maze_to_csr_graph_core: directed and random mazes
// depends on gmcsr_pkg, gmcsr_tb_pkg and the block's rtl
module grid_maze_to_csr_graph_core_tb;

   import gmcsr_pkg::*;
   import gmcsr_tb_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 1200;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_wen;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   maze_record_board board;
   int send_gap_pct;
   int stall_pct;
   bit hold_off_req;
   int quiet_cycles = 0;

   grid_maze_to_csr_graph_core #(
      .MAX_WIDTH  (MAZE_MAX_W),
      .MAX_HEIGHT (MAZE_MAX_H)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stall, or a long hold-off when asked
   initial begin
      int hold_cnt;
      hold_cnt = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            rsp_stall <= 1'b1;
            hold_cnt--;
         end else if (hold_off_req) begin
            hold_off_req = 0;
            hold_cnt = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_record(rsp_data);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wen) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void set_idling(int gap, int stall);
      send_gap_pct = gap;
      stall_pct = stall;
   endfunction

   // offers one item and waits for its transfer
   task automatic send_item(input logic mode, input logic [7:0] ch);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.mode <= mode;
      req_data.cell_char <= ch;
      do @(posedge clock); while (req_stall);
      board.predict_from_item(req_data);
   endtask

   task automatic send_drain();
      send_item(MODE_DRAIN, 8'($urandom_range(255)));
   endtask

   // lower valid and wait until every due record has come out
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.due_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_register(idx, value);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_size(input logic [CSR_DATA_W-1:0] w,
                           input logic [CSR_DATA_W-1:0] h);
      wait_idle();
      write_register(CSR_GRID_WIDTH, w);
      write_register(CSR_GRID_HEIGHT, h);
   endtask

   // mostly maze characters, now and then any byte
   function automatic logic [7:0] pick_cell(int wall_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return 8'($urandom_range(255));
      if (roll < 8) return CH_START;
      if (roll < 12) return CH_DEST;
      if ($urandom_range(99) < wall_pct) return CH_WALL;
      return CH_OPEN;
   endfunction

   // a full maze with its drain steps, sprinkled with items the block drops
   task automatic play_maze(input int wall_pct, input int noise_pct);
      int unsigned w;
      int unsigned h;
      w = board.cols();
      h = board.rows();
      for (int unsigned n = 0; n < w * h; n++) begin
         if ($urandom_range(99) < noise_pct) send_drain();
         send_item(MODE_CELL, pick_cell(wall_pct));
      end
      for (int unsigned n = 0; n <= w; n++) begin
         if ($urandom_range(99) < noise_pct) send_item(MODE_CELL, pick_cell(wall_pct));
         send_drain();
      end
   endtask

   initial begin
      int counted;
      int maze_no;
      int unsigned cells;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wen = 1'b0;
      csr_index = CSR_GRID_WIDTH;
      csr_wdata = '0;
      hold_off_req = 0;
      set_idling(0, 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset sizes 1 x 1: early drain, start cell, stray cell, closing drains
      send_drain();
      send_item(MODE_CELL, CH_START);
      send_item(MODE_CELL, CH_DEST);
      send_drain();
      send_drain();

      // zero sizes clamp to 1; a maze with no open cell gives no record
      set_size(0, 0);
      send_item(MODE_CELL, CH_WALL);
      send_drain();
      send_drain();

      // two starts and one end, unknown characters at both byte extremes
      set_size(4, 2);
      send_item(MODE_CELL, CH_OPEN);
      send_item(MODE_CELL, CH_START);
      send_item(MODE_CELL, CH_DEST);
      send_item(MODE_CELL, CH_WALL);
      send_item(MODE_CELL, CH_START);
      send_item(MODE_CELL, 8'hff);
      send_item(MODE_CELL, CH_OPEN);
      send_item(MODE_CELL, 8'h00);
      repeat (5) send_drain();

      // maze abandoned by a size write, held record dropped
      set_size(2, 2);
      repeat (3) send_item(MODE_CELL, CH_OPEN);

      // long receiver hold-off while the sender keeps going
      set_idling(0, 0);
      set_size(16, 12);
      hold_off_req = 1;
      play_maze(30, 0);
      counted = 16 * 12 + 17;

      // random small mazes through the idling phases
      maze_no = 0;
      while (counted < RANDOM_ITEMS) begin
         case ((maze_no / 3) % 4)
            0: set_idling(0, 0);
            1: set_idling(70, 0);
            2: set_idling(0, 70);
            default: set_idling(38, 38);
         endcase
         set_size(CSR_DATA_W'($urandom_range(0, 12)), CSR_DATA_W'($urandom_range(0, 10)));
         cells = board.cols() * board.rows();
         if ($urandom_range(9) == 0) begin
            // broken maze, cut off by the next size write
            cells = $urandom_range(0, cells);
            repeat (cells) send_item(MODE_CELL, pick_cell(40));
            counted += cells;
         end else begin
            play_maze($urandom_range(5, 60), 3);
            counted += cells + board.cols() + 1;
         end
         maze_no++;
      end

      wait_idle();
      if (board.errors == 0 && board.due_count() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
